[hdl/pdsc_pkg.sv]
// pdsc_pkg: shared constants and types for the packet deframer with additive checksum
// holds the buffer sizing, framing bytes and parser phase encoding
// no dependencies
package pdsc_pkg;

   // payload buffer sizing
   localparam int BUF_DEPTH = 256;
   localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   // read index limit (9 bits so that a depth of 256 fits)
   localparam logic [8:0] IDX_LIMIT = 9'(BUF_DEPTH);
   // last usable write position
   localparam logic [7:0] POS_LAST  = 8'(BUF_DEPTH - 1);

   // framing bytes
   localparam logic [7:0] PREAMBLE_FIRST  = 8'hBE;
   localparam logic [7:0] PREAMBLE_SECOND = 8'hEF;
   localparam int         BYTE_BITS       = 8;

   // request command codes
   localparam logic CMD_STREAM = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // parser phases, one-hot
   typedef enum logic [5:0] {
      PH_PRE0 = 6'b000001,
      PH_PRE1 = 6'b000010,
      PH_LEN  = 6'b000100,
      PH_PAY  = 6'b001000,
      PH_CS0  = 6'b010000,
      PH_CS1  = 6'b100000
   } phase_type;

endpackage

[hdl/packet_deframer_sum_checksum.sv]
// packet_deframer_sum_checksum: byte stream deframer with 16-bit additive checksum
// parser, payload buffer and two-stage result path with stall handling
// depends on pdsc_pkg
//
// Takes one transaction per cycle on the req_ channel while req_stall is low.
// With req_command low, req_data_byte is the next byte of a stream framed as
// BE EF, a length byte (1..255), that many payload bytes and a 16-bit checksum
// sent low byte first; the checksum is the wrapping 16-bit sum of the length
// byte and the payload. With req_command high, the payload buffer entry at
// req_read_index is returned on rsp_read_data (zero for an index at or beyond
// the buffer depth). Every request gives exactly one rsp_ transaction. When
// the last checksum byte matches, rsp_packet_ok is set together with the
// packet length and its first payload byte; all other fields read zero. Bad
// checksums are dropped silently. Throughput is one transaction per clock: the
// parser compare, the 16-bit add and the buffer write all settle within the
// accepting cycle. A result passes the buffer read register, then the output
// register. The two stages let one more request be taken while a finished
// result is held by rsp_stall. Buffer entries are valid only once written by a
// packet and until the next packet overwrites them; no clearing pass is run.
module packet_deframer_sum_checksum (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_read_index,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_packet_ok,
   output logic [7:0] rsp_first_byte,
   output logic [7:0] rsp_packet_length,
   output logic [7:0] rsp_read_data
);
   import pdsc_pkg::*;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  exp_len_ff, exp_len_in;
   logic [7:0]  wr_pos_ff, wr_pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  rx_low_ff, rx_low_in;
   // copy of buffer entry 0 so the good-packet result needs no second read port
   logic [7:0]  first_ff, first_in;

   // payload buffer
   logic [7:0]  buf_mem [BUF_DEPTH];
   logic        buf_we;
   logic [7:0]  rd_ff;

   // stage a: result fields of the transaction just accepted
   logic        a_valid_ff, a_valid_in;
   logic        a_ok_ff, a_ok_in;
   logic [7:0]  a_first_ff, a_first_in;
   logic [7:0]  a_len_ff, a_len_in;
   logic        a_rd_sel_ff, a_rd_sel_in;

   // stage b: output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ok_ff;
   logic [7:0]  rsp_first_ff;
   logic [7:0]  rsp_len_ff;
   logic [7:0]  rsp_rd_ff;

   logic        req_accept;
   logic        b_load;
   logic        stream_byte;
   logic [15:0] rx_sum;

   // handshake: stage a moves on when the output register is empty or drained
   assign b_load     = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = a_valid_ff && !b_load;
   assign req_accept = req_valid && !req_stall;
   assign stream_byte = req_accept && (req_command == CMD_STREAM);

   assign rx_sum = {req_data_byte, rx_low_ff};

   // parser next state and result of a stream byte
   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      wr_pos_in  = wr_pos_ff;
      sum_in     = sum_ff;
      rx_low_in  = rx_low_ff;
      first_in   = first_ff;
      buf_we     = 1'b0;
      a_ok_in    = 1'b0;
      a_first_in = '0;
      a_len_in   = '0;
      if (stream_byte) begin
         unique case (phase_ff)
            PH_PRE0: begin
               // hunting: every byte here restarts the sum
               if (req_data_byte == PREAMBLE_FIRST) begin
                  phase_in = PH_PRE1;
               end
               sum_in = '0;
            end
            PH_PRE1: begin
               // anything but the second preamble byte is ignored
               if (req_data_byte == PREAMBLE_SECOND) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (req_data_byte != 8'd0) begin
                  exp_len_in = req_data_byte;
                  wr_pos_in  = '0;
                  phase_in   = PH_PAY;
                  sum_in     = sum_ff + {8'd0, req_data_byte};
               end else begin
                  phase_in = PH_PRE0;
               end
            end
            PH_PAY: begin
               buf_we = 1'b1;
               if (wr_pos_ff == 8'd0) begin
                  first_in = req_data_byte;
               end
               sum_in = sum_ff + {8'd0, req_data_byte};
               if (({1'b0, wr_pos_ff} + 9'd1) == {1'b0, exp_len_ff}) begin
                  phase_in = PH_CS0;
               end
               // saturate at the last entry
               if (wr_pos_ff < POS_LAST) begin
                  wr_pos_in = wr_pos_ff + 8'd1;
               end
            end
            PH_CS0: begin
               rx_low_in = req_data_byte;
               phase_in  = PH_CS1;
            end
            PH_CS1: begin
               phase_in = PH_PRE0;
               if (rx_sum == sum_ff) begin
                  a_ok_in    = 1'b1;
                  a_first_in = first_ff;
                  a_len_in   = exp_len_ff;
               end
            end
            default: begin
               phase_in = PH_PRE0;
            end
         endcase
      end
   end

   // read commands return data only for indexes inside the buffer
   assign a_rd_sel_in = (req_command == CMD_READ) && ({1'b0, req_read_index} < IDX_LIMIT);

   assign a_valid_in   = req_accept || (a_valid_ff && !b_load);
   assign rsp_valid_in = b_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PRE0;
         exp_len_ff   <= '0;
         wr_pos_ff    <= '0;
         sum_ff       <= '0;
         rx_low_ff    <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         exp_len_ff   <= exp_len_in;
         wr_pos_ff    <= wr_pos_in;
         sum_ff       <= sum_in;
         rx_low_ff    <= rx_low_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[wr_pos_ff[ADDR_W-1:0]] <= req_data_byte;
      end
      if (req_accept) begin
         rd_ff <= buf_mem[req_read_index[ADDR_W-1:0]];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      if (req_accept) begin
         a_ok_ff     <= a_ok_in;
         a_first_ff  <= a_first_in;
         a_len_ff    <= a_len_in;
         a_rd_sel_ff <= a_rd_sel_in;
      end
      if (b_load) begin
         rsp_ok_ff    <= a_ok_ff;
         rsp_first_ff <= a_first_ff;
         rsp_len_ff   <= a_len_ff;
         rsp_rd_ff    <= a_rd_sel_ff ? rd_ff : 8'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_ok     = rsp_ok_ff;
   assign rsp_first_byte    = rsp_first_ff;
   assign rsp_packet_length = rsp_len_ff;
   assign rsp_read_data     = rsp_rd_ff;

   // a good packet always carries a nonzero length
   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_ok |-> rsp_packet_length != 8'd0)
      else $error("good packet with zero length");

   // packet report and read data never share a transaction
   a_ok_rd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_ok |-> rsp_read_data == 8'd0)
      else $error("read data on a packet report");

   // the input only stalls when both stages hold a result
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // a read command leaves the parser untouched
   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_command == CMD_READ |=> $stable(phase_ff) && $stable(sum_ff))
      else $error("read command changed parser state");

   // write position stays inside the buffer
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      wr_pos_ff <= POS_LAST)
      else $error("write position beyond buffer");

endmodule

[test/packet_deframer_sum_checksum_tb.sv]
// packet_deframer_sum_checksum_tb: self-checking bench for the byte stream deframer
// a directed table, then random framed packets under three idle mixes, checked by a predictor
// depends on pdsc_pkg and packet_deframer_sum_checksum
`timescale 1ns / 100ps

module packet_deframer_sum_checksum_tb;
   import pdsc_pkg::*;

   // generous: ~1400 transactions, each with room to spare for gaps and stalls
   localparam int CYCLE_LIMIT = 200_000;

   // one result transaction
   typedef struct packed {
      logic       ok;
      logic [7:0] first;
      logic [7:0] pkt_len;
      logic [7:0] rdata;
   } outcome_type;

   localparam outcome_type QUIET = '0;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      logic        cmd;
      logic [7:0]  data;
      logic [7:0]  idx;
      logic        typed;
      outcome_type want;
   } dir_row_type;

   localparam int DIR_ROWS = 23;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_command = CMD_STREAM;
   logic [7:0] req_data_byte = 8'h00;
   logic [7:0] req_read_index = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_packet_ok;
   logic [7:0] rsp_first_byte;
   logic [7:0] rsp_packet_length;
   logic [7:0] rsp_read_data;

   // shadow of the parser and the payload buffer
   phase_type   prs_phase = PH_PRE0;
   logic [7:0]  prs_len = '0;
   logic [7:0]  prs_pos = '0;
   logic [15:0] prs_sum = '0;
   logic [7:0]  prs_sum_lo = '0;
   logic [7:0]  shadow_store [BUF_DEPTH];
   int          shadow_top = 0;   // entries 0 .. shadow_top-1 have been written

   outcome_type outcome_q [$];

   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int cycle_count    = 0;
   int mismatches     = 0;
   int results_seen   = 0;
   int items_sent     = 0;
   int good_pkts      = 0;
   int spoiled_pkts   = 0;
   int reads_sent     = 0;

   // directed table: hunting noise, second preamble mismatch, zero length, smallest
   // packet with the largest byte, a read, read during parsing, checksum mismatch
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{CMD_STREAM, 8'h00, 8'hFF, 1'b1, QUIET},             // noise while hunting
      '{CMD_STREAM, 8'hFF, 8'h00, 1'b1, QUIET},
      '{CMD_STREAM, 8'hBE, 8'hFF, 1'b1, QUIET},
      '{CMD_STREAM, 8'h12, 8'h00, 1'b1, QUIET},             // not EF, keep waiting
      '{CMD_STREAM, 8'hEF, 8'hFF, 1'b1, QUIET},
      '{CMD_STREAM, 8'h00, 8'h00, 1'b1, QUIET},             // zero length, back to hunt
      '{CMD_STREAM, 8'hBE, 8'hFF, 1'b1, QUIET},
      '{CMD_STREAM, 8'hEF, 8'h00, 1'b1, QUIET},
      '{CMD_STREAM, 8'h01, 8'hFF, 1'b1, QUIET},             // length 1
      '{CMD_STREAM, 8'hFF, 8'h00, 1'b1, QUIET},             // payload FF
      '{CMD_STREAM, 8'h00, 8'hFF, 1'b1, QUIET},             // sum 0x0100, low byte
      '{CMD_STREAM, 8'h01, 8'h00, 1'b1, '{1'b1, 8'hFF, 8'h01, 8'h00}},
      '{CMD_READ,   8'hA5, 8'h00, 1'b1, '{1'b0, 8'h00, 8'h00, 8'hFF}},
      '{CMD_STREAM, 8'hBE, 8'hFF, 1'b1, QUIET},
      '{CMD_STREAM, 8'hEF, 8'h00, 1'b1, QUIET},
      '{CMD_STREAM, 8'h02, 8'hFF, 1'b1, QUIET},
      '{CMD_STREAM, 8'h00, 8'h00, 1'b1, QUIET},
      '{CMD_READ,   8'h5A, 8'h00, 1'b0, QUIET},             // read in mid payload
      '{CMD_STREAM, 8'h80, 8'hFF, 1'b1, QUIET},
      '{CMD_STREAM, 8'h83, 8'h00, 1'b1, QUIET},             // sum is 0x0082, sent 0x0083
      '{CMD_STREAM, 8'h00, 8'hFF, 1'b1, QUIET},             // dropped silently
      '{CMD_READ,   8'h00, 8'h01, 1'b0, QUIET},
      '{CMD_READ,   8'hFF, 8'h00, 1'b0, QUIET}
   };

   packet_deframer_sum_checksum dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_data_byte     (req_data_byte),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_packet_ok     (rsp_packet_ok),
      .rsp_first_byte    (rsp_first_byte),
      .rsp_packet_length (rsp_packet_length),
      .rsp_read_data     (rsp_read_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results pending", cycle_count,
                  outcome_q.size());
         $display("packet_deframer_sum_checksum_tb NOT OK");
         $finish;
      end
   end

   // receiver back-pressure, re-rolled every falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
   end

   // shadow parser: advances on one transaction and works out its result
   task automatic predict_outcome(input logic cmd, input logic [7:0] b, input logic [7:0] idx,
                                  output outcome_type o);
      logic [15:0] rx_sum;
      o = QUIET;
      if (cmd == CMD_READ) begin
         if ({1'b0, idx} < IDX_LIMIT) begin
            o.rdata = shadow_store[idx];
         end
      end else begin
         case (prs_phase)
            PH_PRE0: begin
               // every hunting byte clears the sum
               if (b == PREAMBLE_FIRST) begin
                  prs_phase = PH_PRE1;
               end
               prs_sum = '0;
            end
            PH_PRE1: begin
               // anything but EF is ignored here
               if (b == PREAMBLE_SECOND) begin
                  prs_phase = PH_LEN;
               end
            end
            PH_LEN: begin
               if (b != 8'h00) begin
                  prs_len   = b;
                  prs_pos   = '0;
                  prs_phase = PH_PAY;
                  prs_sum   = prs_sum + 16'(b);
               end else begin
                  prs_phase = PH_PRE0;
               end
            end
            PH_PAY: begin
               if ({1'b0, prs_pos} < IDX_LIMIT) begin
                  shadow_store[prs_pos] = b;
                  if (int'(prs_pos) >= shadow_top) begin
                     shadow_top = int'(prs_pos) + 1;
                  end
               end
               prs_sum = prs_sum + 16'(b);
               if (9'(prs_pos) + 9'd1 == 9'(prs_len)) begin
                  prs_phase = PH_CS0;
               end
               // write position saturates at the last entry
               if (prs_pos < POS_LAST) begin
                  prs_pos = prs_pos + 8'd1;
               end
            end
            PH_CS0: begin
               prs_sum_lo = b;
               prs_phase  = PH_CS1;
            end
            PH_CS1: begin
               rx_sum    = {b, prs_sum_lo};
               prs_phase = PH_PRE0;
               if (rx_sum == prs_sum) begin
                  o.ok      = 1'b1;
                  o.first   = shadow_store[0];
                  o.pkt_len = prs_len;
               end
            end
            default: prs_phase = PH_PRE0;
         endcase
      end
   endtask

   // send one transaction; returns at the falling edge after it was taken
   task automatic push_req(input logic cmd, input logic [7:0] b, input logic [7:0] idx,
                           input logic typed, input outcome_type typed_want);
      outcome_type predicted;
      predict_outcome(cmd, b, idx, predicted);
      outcome_q.push_back(typed ? typed_want : predicted);
      items_sent++;
      if (predicted.ok) good_pkts++;
      if (cmd == CMD_READ) reads_sent++;
      // sender gaps
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_data_byte  <= b;
      req_read_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_req(CMD_STREAM, b, 8'($urandom), 1'b0, QUIET);
   endtask

   // now and then look into the buffer, only at entries already written
   task automatic maybe_read();
      if (shadow_top > 0 && $urandom_range(0, 9) == 0) begin
         push_req(CMD_READ, 8'($urandom), 8'($urandom_range(0, shadow_top - 1)), 1'b0, QUIET);
      end
   endtask

   // one framed packet; optionally a spoiled checksum, all-FF payload or junk after BE
   task automatic push_packet(input int len, input bit spoil, input bit all_ones,
                              input bit junk_pre1);
      logic [15:0] sum;
      logic [7:0]  pb;
      sum = 16'(len);
      push_byte(PREAMBLE_FIRST);
      if (junk_pre1) begin
         repeat ($urandom_range(1, 3)) begin
            pb = 8'($urandom);
            if (pb == PREAMBLE_SECOND) pb = 8'h00;
            push_byte(pb);
         end
      end
      maybe_read();
      push_byte(PREAMBLE_SECOND);
      push_byte(8'(len));
      for (int i = 0; i < len; i++) begin
         pb  = all_ones ? 8'hFF : 8'($urandom);
         sum = sum + 16'(pb);
         push_byte(pb);
         maybe_read();
      end
      if (spoil) begin
         sum = sum ^ (16'd1 << $urandom_range(0, 15));
         spoiled_pkts++;
      end
      push_byte(sum[7:0]);
      push_byte(sum[15:8]);
   endtask

   // bring the parser back to hunting so the next packet frames cleanly
   task automatic resync();
      while (prs_phase != PH_PRE0) begin
         case (prs_phase)
            PH_PRE1: push_byte(PREAMBLE_SECOND);
            PH_LEN:  push_byte(8'h00);
            default: push_byte(8'($urandom));
         endcase
      end
   endtask

   // mostly good packets with random content, the rest broken framing and noise
   task automatic run_random(input int n_items);
      int start;
      int pick;
      int len;
      start = items_sent;
      while (items_sent - start < n_items) begin
         resync();
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
         if (pick < 70) begin
            push_packet(len, 1'b0, pick < 7, 1'b0);
         end else if (pick < 78) begin
            push_packet(len, 1'b1, 1'b0, 1'b0);
         end else if (pick < 84) begin
            push_packet(len, 1'b0, 1'b0, 1'b1);
         end else if (pick < 88) begin
            push_byte(PREAMBLE_FIRST);
            push_byte(PREAMBLE_SECOND);
            push_byte(8'h00);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               push_byte(8'($urandom));
               maybe_read();
            end
         end
      end
   endtask

   // hold the sender off until every pending result is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outcome_q.size() != 0);
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      $display("mismatch on %s at result %0d: got %0h, want %0h", field, results_seen,
               got, want);
   endtask

   // result monitor: every accepted result against the oldest pending one
   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("result with nothing pending", 1, 0);
         end else begin
            w = outcome_q.pop_front();
            if (rsp_packet_ok !== w.ok)
               report_mismatch("packet_ok", int'(rsp_packet_ok), int'(w.ok));
            if (rsp_first_byte !== w.first)
               report_mismatch("first_byte", int'(rsp_first_byte), int'(w.first));
            if (rsp_packet_length !== w.pkt_len)
               report_mismatch("packet_length", int'(rsp_packet_length), int'(w.pkt_len));
            if (rsp_read_data !== w.rdata)
               report_mismatch("read_data", int'(rsp_read_data), int'(w.rdata));
         end
         results_seen++;
      end
   end

   initial begin
      for (int i = 0; i < BUF_DEPTH; i++) shadow_store[i] = 8'h00;
      // hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // phase 1: sender idles 36%, receiver stalls 59%
      src_idle_pct   = 36;
      sink_stall_pct = 59;
      for (int r = 0; r < DIR_ROWS; r++) begin
         push_req(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].idx,
                  directed_rows[r].typed, directed_rows[r].want);
      end
      // longest packet fills entries 0..254 so reads reach up to entry 254
      push_packet(255, 1'b0, 1'b0, 1'b0);
      run_random(180);
      drain();

      // phase 2: the other way round
      src_idle_pct   = 59;
      sink_stall_pct = 36;
      run_random(450);
      drain();

      // phase 3: back to back
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      run_random(450);

      drain();
      repeat (8) @(negedge clock);

      $display("covered %0d transactions: %0d good packets, %0d spoiled checksums, %0d reads",
               items_sent, good_pkts, spoiled_pkts, reads_sent);
      $display("three idle mixes, %0d results compared, %0d mismatches",
               results_seen, mismatches);
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("packet_deframer_sum_checksum_tb OK");
      end else begin
         $display("packet_deframer_sum_checksum_tb NOT OK");
      end
      $finish;
   end

endmodule
